// File: sv/sspc_pkg.sv
// ----------------------------------------------------------------------------
// sspc_pkg
// Shared widths, defaults and controller/datapath types for the subset-sum
// partition counter.
// ----------------------------------------------------------------------------
package sspc_pkg;

    localparam int MAX_SUM_DEF    = 1023;
    localparam int COUNT_BITS_DEF = 32;

    localparam int VALUE_W  = 10;
    localparam int DIFF_W   = 10;
    localparam int RESULT_W = 32;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_DRAIN,
        ST_ANS_READ,
        ST_RESULT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic upd_read;
        logic ans_read;
        logic out_load;
        logic clr_write;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic skip;
        logic last;
        logic upd_end;
        logic clr_end;
        logic out_full;
    } t_dp_status;

endpackage

// File: sv/sspc_ctrl.sv
// ----------------------------------------------------------------------------
// sspc_ctrl
// Sequencer for table clearing, per-member table sweep and result readout.
// ----------------------------------------------------------------------------
module sspc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sspc_pkg::t_dp_status  i_status,
    output sspc_pkg::t_dp_cmd     o_cmd
);

    sspc_pkg::t_state r_state;
    sspc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sspc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            sspc_pkg::ST_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_status.clr_end) begin
                    n_state = sspc_pkg::ST_IDLE;
                end
            end
            sspc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = sspc_pkg::ST_UPDATE;
                end
            end
            sspc_pkg::ST_UPDATE: begin
                if (i_status.skip) begin
                    // member beyond the table: no sweep
                    n_state = i_status.last ? sspc_pkg::ST_ANS_READ : sspc_pkg::ST_IDLE;
                end else begin
                    o_cmd.upd_read = 1'b1;
                    if (i_status.upd_end) begin
                        n_state = sspc_pkg::ST_DRAIN;
                    end
                end
            end
            sspc_pkg::ST_DRAIN: begin
                n_state = i_status.last ? sspc_pkg::ST_ANS_READ : sspc_pkg::ST_IDLE;
            end
            sspc_pkg::ST_ANS_READ: begin
                o_cmd.ans_read = 1'b1;
                n_state        = sspc_pkg::ST_RESULT;
            end
            sspc_pkg::ST_RESULT: begin
                if (!i_status.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = sspc_pkg::ST_CLEAR;
                end
            end
            default: begin
                n_state = sspc_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// File: sv/sspc_dpath.sv
// ----------------------------------------------------------------------------
// sspc_dpath
// Count table memory, saturating update adder, running total, answer select
// and result register.
// ----------------------------------------------------------------------------
module sspc_dpath #(
    parameter int MAX_SUM    = sspc_pkg::MAX_SUM_DEF,
    parameter int COUNT_BITS = sspc_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sspc_pkg::t_dp_cmd             i_cmd,
    output sspc_pkg::t_dp_status          o_status,
    input  logic                          i_cfg_we,
    input  logic [sspc_pkg::DIFF_W-1:0]   i_cfg_target_difference,
    input  logic [sspc_pkg::VALUE_W-1:0]  i_element_value,
    input  logic                          i_last_element,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sspc_pkg::RESULT_W-1:0] o_partition_count,
    output logic                          o_overflowed
);

    localparam int DEPTH = MAX_SUM + 1;
    localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int TW    = $clog2(MAX_SUM + 2);
    localparam int SW    = ((TW > sspc_pkg::DIFF_W) ? TW : sspc_pkg::DIFF_W) + 1;
    localparam int CX    = (COUNT_BITS > sspc_pkg::RESULT_W) ? COUNT_BITS
                                                              : sspc_pkg::RESULT_W;

    logic [COUNT_BITS-1:0]        r_mem [DEPTH];
    logic [AW-1:0]                r_addr;
    logic [sspc_pkg::VALUE_W-1:0] r_value;
    logic                         r_last;
    logic [TW-1:0]                r_total;
    logic                         r_flag;
    logic [sspc_pkg::DIFF_W-1:0]  r_tdiff;
    logic [COUNT_BITS-1:0]        r_rd_a;
    logic [COUNT_BITS-1:0]        r_rd_b;
    logic                         r_wr_vld;
    logic [AW-1:0]                r_wr_addr;
    logic                         r_out_valid;
    logic [sspc_pkg::RESULT_W-1:0] r_out_count;
    logic                         r_out_flag;

    logic [AW-1:0]         w_addr_b;
    logic [AW-1:0]         w_addr_a;
    logic [COUNT_BITS:0]   w_add;
    logic                  w_sat;
    logic [COUNT_BITS-1:0] w_sum;
    logic [SW-1:0]         w_tot_next;
    logic                  w_tot_ovf;
    logic [SW-1:0]         w_tsum;
    logic [SW-1:0]         w_s1;
    logic                  w_ans_ok;
    logic [CX-1:0]         w_cnt_x;
    logic                  w_wide;

    // partner entry k - v
    assign w_addr_b = r_addr - AW'(r_value);

    // answer index s1 = (total + difference) / 2
    assign w_tsum   = SW'(r_total) + SW'(r_tdiff);
    assign w_s1     = w_tsum >> 1;
    assign w_addr_a = i_cmd.ans_read ? AW'(w_s1) : r_addr;
    assign w_ans_ok = (SW'(r_total) <= SW'(MAX_SUM)) && (SW'(r_tdiff) <= SW'(r_total))
                      && !w_tsum[0] && (w_s1 <= SW'(MAX_SUM));

    // saturating table update
    assign w_add = {1'b0, r_rd_a} + {1'b0, r_rd_b};
    assign w_sat = w_add[COUNT_BITS];
    assign w_sum = w_sat ? '1 : w_add[COUNT_BITS-1:0];

    assign w_tot_next = SW'(r_total) + SW'(i_element_value);
    assign w_tot_ovf  = w_tot_next > SW'(MAX_SUM);

    // clamp the selected count to the result width
    assign w_cnt_x = w_ans_ok ? CX'(r_rd_a) : '0;
    assign w_wide  = w_cnt_x > CX'({sspc_pkg::RESULT_W{1'b1}});

    // memory write port: clear sweep or delayed update write
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_write) begin
            r_mem[r_addr] <= COUNT_BITS'(r_addr == '0);
        end else if (r_wr_vld) begin
            r_mem[r_wr_addr] <= w_sum;
        end
    end

    // memory read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_read || i_cmd.ans_read) begin
            r_rd_a <= r_mem[w_addr_a];
        end
        if (i_cmd.upd_read) begin
            r_rd_b    <= r_mem[w_addr_b];
            r_wr_addr <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_value <= i_element_value;
            r_last  <= i_last_element;
        end
        if (i_cmd.out_load) begin
            r_out_count <= w_wide ? '1 : w_cnt_x[sspc_pkg::RESULT_W-1:0];
            r_out_flag  <= r_flag | w_wide;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= AW'(MAX_SUM);
            r_total     <= '0;
            r_flag      <= 1'b0;
            r_tdiff     <= '0;
            r_wr_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_vld <= i_cmd.upd_read;
            if (i_cfg_we) begin
                r_tdiff <= i_cfg_target_difference;
            end
            if (i_cmd.accept || i_cmd.out_load) begin
                r_addr <= AW'(MAX_SUM);
            end else if (i_cmd.upd_read || i_cmd.clr_write) begin
                r_addr <= r_addr - AW'(1);
            end
            if (i_cmd.accept) begin
                r_total <= w_tot_ovf ? TW'(MAX_SUM + 1) : TW'(w_tot_next);
                if (w_tot_ovf) begin
                    r_flag <= 1'b1;
                end
            end else if (i_cmd.out_load) begin
                // start a fresh set
                r_total <= '0;
                r_flag  <= 1'b0;
            end else if (r_wr_vld && w_sat) begin
                r_flag <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.skip     = 32'(r_value) > 32'(MAX_SUM);
    assign o_status.last     = r_last;
    assign o_status.upd_end  = r_addr == AW'(r_value);
    assign o_status.clr_end  = r_addr == '0;
    assign o_status.out_full = r_out_valid;

    assign o_out_valid       = r_out_valid;
    assign o_partition_count = r_out_count;
    assign o_overflowed      = r_out_flag;

endmodule

// File: sv/subset_sum_partition_counter_core.sv
// Members: one table entry is updated per cycle through the single write port of the
//   count memory; a member with value > MAX_SUM skips the table sweep. After the last
//   member the answer entry is read and loaded into the result register.
// After each result, and after reset, a clearing pass rewrites the table (entry zero
//   to one, others zero) with the input not ready.
// Reset: synchronous active low; difference register returns to zero.
// ----------------------------------------------------------------------------
// subset_sum_partition_counter_core
// Counts subsets of a streamed member set that reach each sum, and on the last
// member reports how many two-way splits differ by the configured difference.
// ----------------------------------------------------------------------------
module subset_sum_partition_counter_core #(
    parameter int MAX_SUM    = sspc_pkg::MAX_SUM_DEF,
    parameter int COUNT_BITS = sspc_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sspc_pkg::DIFF_W-1:0]   i_cfg_target_difference,
    // member request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sspc_pkg::VALUE_W-1:0]  i_element_value,
    input  logic                          i_last_element,
    // result request channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sspc_pkg::RESULT_W-1:0] o_partition_count,
    output logic                          o_overflowed
);

    sspc_pkg::t_dp_cmd    w_cmd;
    sspc_pkg::t_dp_status w_status;

    // configuration is always taken; the user must write it only while the block is idle; not enforced
    assign o_cfg_ready = 1'b1;

    // sequence: clear sweep -> idle -> descending table sweep and drain per member -> answer -> result -> clear
    sspc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // table memory, adder and result register; the result register holds a
    // finished request while the table is cleared for the next set
    sspc_dpath #(
        .MAX_SUM    (MAX_SUM),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cmd                   (w_cmd),
        .o_status                (w_status),
        .i_cfg_we                (i_cfg_valid & o_cfg_ready),
        .i_cfg_target_difference (i_cfg_target_difference),
        .i_element_value         (i_element_value),
        .i_last_element          (i_last_element),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (i_out_ready),
        .o_partition_count       (o_partition_count),
        .o_overflowed            (o_overflowed)
    );

endmodule
